[src/ptw_pkg.sv]
// Shared types and constants of the page table walker.
// Used by the channel interfaces and by page_table_walker; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package ptw_pkg;

  localparam int StoreWordsDefault = 4096;

  // Field widths of the two channels.
  localparam int REQ_TYPE_W = 3;
  localparam int VA_W       = 64;
  localparam int WIDX_W     = 12;
  localparam int WORD_W     = 64;
  localparam int PA_W       = 48;
  localparam int STATUS_W   = 3;
  localparam int LEVEL_W    = 2;

  // Request codes. Codes above REQ_MAKE_EXEC are walked like REQ_WALK.
  localparam logic [REQ_TYPE_W-1:0] REQ_WALK      = 3'd0;
  localparam logic [REQ_TYPE_W-1:0] REQ_WRITE     = 3'd1;
  localparam logic [REQ_TYPE_W-1:0] REQ_MAKE_RW   = 3'd2;
  localparam logic [REQ_TYPE_W-1:0] REQ_MAKE_RO   = 3'd3;
  localparam logic [REQ_TYPE_W-1:0] REQ_MAKE_EXEC = 3'd4;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ALREADY  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OUTSIDE  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NO_LEAF  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_GRANULE  = 3'd5;
  localparam logic [STATUS_W-1:0] ST_SIZE     = 3'd6;

  // Granule select codes.
  localparam logic [1:0] GRAN_NONE = 2'd0;
  localparam logic [1:0] GRAN_16K  = 2'd1;
  localparam logic [1:0] GRAN_4K   = 2'd2;
  localparam logic [1:0] GRAN_64K  = 2'd3;

  // Configuration register indexes (byte address is eight times the index).
  localparam logic [1:0] REG_GRANULE   = 2'd0;
  localparam logic [1:0] REG_VA_SIZE   = 2'd1;
  localparam logic [1:0] REG_LOW_BASE  = 2'd2;
  localparam logic [1:0] REG_HIGH_BASE = 2'd3;

  // Descriptor bit positions.
  localparam int BIT_VALID = 0;
  localparam int BIT_TABLE = 1;
  localparam int BIT_USER  = 6;
  localparam int BIT_RO    = 7;
  localparam int BIT_PXN   = 53;
  localparam int BIT_UXN   = 54;
  localparam int BIT_HIGH  = 63;

endpackage
`default_nettype wire

[src/ptw_req_if.sv]
// Request channel of the page table walker: valid/ready plus one request word.
// Depends on ptw_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none
interface ptw_req_if;
  logic                           valid;
  logic                           ready;
  logic [ptw_pkg::REQ_TYPE_W-1:0] req_type;
  logic [ptw_pkg::VA_W-1:0]       virt_addr;
  logic [ptw_pkg::WIDX_W-1:0]     word_index;
  logic [ptw_pkg::WORD_W-1:0]     word_value;

  modport source(output valid, output req_type, output virt_addr, output word_index,
                 output word_value, input ready);
  modport sink(input valid, input req_type, input virt_addr, input word_index,
               input word_value, output ready);
endinterface
`default_nettype wire

[src/ptw_rsp_if.sv]
// Result channel of the page table walker: valid/ready plus one result word.
// Depends on ptw_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none
interface ptw_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [ptw_pkg::STATUS_W-1:0] status;
  logic                         found;
  logic [ptw_pkg::WORD_W-1:0]   leaf_entry;
  logic [ptw_pkg::LEVEL_W-1:0]  leaf_level;
  logic [ptw_pkg::PA_W-1:0]     mapped_pa;
  logic [ptw_pkg::PA_W-1:0]     entry_phys;
  logic                         can_write;
  logic                         can_exec;
  logic                         user_ok;

  modport source(output valid, output status, output found, output leaf_entry,
                 output leaf_level, output mapped_pa, output entry_phys, output can_write,
                 output can_exec, output user_ok, input ready);
  modport sink(input valid, input status, input found, input leaf_entry,
               input leaf_level, input mapped_pa, input entry_phys, input can_write,
               input can_exec, input user_ok, output ready);
endinterface
`default_nettype wire

[src/page_table_walker.sv]
// Top level of the page table walker: APB registers, table word store and walk sequencer.
// Depends on ptw_pkg, ptw_req_if and ptw_rsp_if.
//
//   channel | direction | handshake             | word
//   --------+-----------+-----------------------+----------------------------------------
//   req     | in        | valid/ready           | req_type, virt_addr, word_index, value
//   rsp     | out       | valid/ready           | status, leaf fields, permission flags
//   apb     | in        | psel/penable/pready   | 64-bit register write or read
//
// A table word write goes from acceptance in S_IDLE straight to S_FINISH. A walk
// passes S_CHECK and then S_ADDR and S_EVAL for each of the 1 to 4 table levels
// read: S_ADDR forms the entry address and reads the store, S_EVAL decodes the
// entry, and the store's single read port sets that pace. A leaf update is written
// back in the decode cycle. The walker is busy with one word at a time; a finished
// result waits in the output register while rsp.ready is low, and the sequencer
// holds in its final state until that register is free. Reset is synchronous; it
// clears the state, the result valid flag and the configuration registers but not
// the store, whose words are undefined until written, so no clearing pass follows reset.
`timescale 1ns / 1ps
`default_nettype none
module page_table_walker #(
  parameter int STORE_WORDS = ptw_pkg::StoreWordsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  ptw_req_if.sink          req,
  ptw_rsp_if.source        rsp,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic      [63:0] prdata,
  output logic             pready
);

  localparam int AW = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
  localparam int PA_W = ptw_pkg::PA_W;
  localparam int WORD_W = ptw_pkg::WORD_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_ADDR,
    S_EVAL,
    S_FINISH
  } state_t;

  // ---------------------------------------------------------------------------
  // Configuration registers. Change only while the walker is idle; not enforced here.
  // ---------------------------------------------------------------------------
  logic [1:0]      granule_code;
  logic [5:0]      va_size_offset;
  logic [PA_W-1:0] low_table_base;
  logic [PA_W-1:0] high_table_base;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      granule_code    <= ptw_pkg::GRAN_4K;
      va_size_offset  <= 6'd16;
      low_table_base  <= '0;
      high_table_base <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[4:3])
        ptw_pkg::REG_GRANULE:   granule_code    <= pwdata[1:0];
        ptw_pkg::REG_VA_SIZE:   va_size_offset  <= pwdata[5:0];
        ptw_pkg::REG_LOW_BASE:  low_table_base  <= pwdata[PA_W-1:0];
        ptw_pkg::REG_HIGH_BASE: high_table_base <= pwdata[PA_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:3])
      ptw_pkg::REG_GRANULE:   prdata = {62'd0, granule_code};
      ptw_pkg::REG_VA_SIZE:   prdata = {58'd0, va_size_offset};
      ptw_pkg::REG_LOW_BASE:  prdata = {16'd0, low_table_base};
      ptw_pkg::REG_HIGH_BASE: prdata = {16'd0, high_table_base};
    endcase
  end

  // ---------------------------------------------------------------------------
  // Translation regime decode. From the granule we get the page shift and the
  // number of index bits per level; the level count is found by comparing the
  // virtual size against the span covered by one to four levels.
  // ---------------------------------------------------------------------------
  logic [5:0]      pg_shift;
  logic            gran_ok;
  logic [5:0]      lvl_bits;
  logic [6:0]      va_bits;
  logic            size_ok;
  logic [6:0]      span1, span2, span3, span4;
  logic [1:0]      levels_m1;
  logic            too_deep;
  logic [5:0]      s_start;
  logic [PA_W-1:0] addr_mask;

  always_comb begin
    unique case (granule_code)
      ptw_pkg::GRAN_NONE: begin pg_shift = 6'd12; gran_ok = 1'b0; end
      ptw_pkg::GRAN_16K:  begin pg_shift = 6'd14; gran_ok = 1'b1; end
      ptw_pkg::GRAN_4K:   begin pg_shift = 6'd12; gran_ok = 1'b1; end
      ptw_pkg::GRAN_64K:  begin pg_shift = 6'd16; gran_ok = 1'b1; end
    endcase
    lvl_bits  = pg_shift - 6'd3;
    va_bits   = 7'd64 - {1'b0, va_size_offset};
    size_ok   = (va_bits >= 7'd36) && (va_bits <= 7'd52);
    span1     = {1'b0, pg_shift} + {1'b0, lvl_bits};
    span2     = span1 + {1'b0, lvl_bits};
    span3     = span2 + {1'b0, lvl_bits};
    span4     = span3 + {1'b0, lvl_bits};
    levels_m1 = 2'({1'b0, span1 < va_bits} + {1'b0, span2 < va_bits}
                   + {1'b0, span3 < va_bits});
    too_deep  = span4 < va_bits;
    unique case (levels_m1)
      2'd0: s_start = pg_shift;
      2'd1: s_start = span1[5:0];
      2'd2: s_start = span2[5:0];
      2'd3: s_start = span3[5:0];
    endcase
    addr_mask = ~((PA_W'(1) << pg_shift) - PA_W'(1));
  end

  // ---------------------------------------------------------------------------
  // Walk registers.
  // ---------------------------------------------------------------------------
  state_t                       state;
  logic [ptw_pkg::REQ_TYPE_W-1:0] cur_type;
  logic [63:0]                  cur_va;
  logic [PA_W-1:0]              table_base;
  logic [1:0]                   level;
  logic [5:0]                   s_cur;
  logic                         first_level;
  logic [PA_W-1:0]              pa_r;

  logic [ptw_pkg::STATUS_W-1:0] res_status;
  logic                         res_found;
  logic [WORD_W-1:0]            res_entry;
  logic [1:0]                   res_level;
  logic [PA_W-1:0]              res_phys;
  logic [PA_W-1:0]              res_entry_phys;
  logic                         res_write;
  logic                         res_exec;
  logic                         res_user;

  logic                         out_valid;
  logic                         out_free;
  logic                         in_fire;

  assign req.ready = (state == S_IDLE);
  assign in_fire   = req.valid && req.ready;
  assign out_free  = !out_valid || rsp.ready;

  // ---------------------------------------------------------------------------
  // Entry address: slice the index out of the address with the shared shifter
  // and add it, scaled by eight, to the current table base. The top level only
  // sees the address bits below the virtual size.
  // ---------------------------------------------------------------------------
  logic [63:0]     va_mask;
  logic [63:0]     va_lim;
  logic [63:0]     va_shifted;
  logic [12:0]     idx;
  logic [PA_W-1:0] pa_c;
  logic [44:0]     word_c;
  logic            outside;

  always_comb begin
    va_mask    = (64'd1 << va_bits) - 64'd1;
    va_lim     = first_level ? (cur_va & va_mask) : cur_va;
    va_shifted = va_lim >> s_cur;
    idx        = va_shifted[12:0] & ((13'd1 << lvl_bits) - 13'd1);
    pa_c       = table_base + PA_W'({idx, 3'b000});
    word_c     = pa_c[PA_W-1:3];
    outside    = word_c >= 45'(STORE_WORDS);
  end

  // ---------------------------------------------------------------------------
  // Table word store: one write port, one registered read port.
  // ---------------------------------------------------------------------------
  logic [WORD_W-1:0] mem [STORE_WORDS];
  logic [WORD_W-1:0] rd_data;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [WORD_W-1:0] mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[word_c[AW-1:0]];
  end

  // ---------------------------------------------------------------------------
  // Entry decode and leaf update.
  // ---------------------------------------------------------------------------
  logic              is_high;
  logic              next_table;
  logic              leaf_write;
  logic              leaf_exec;
  logic [PA_W-1:0]   low_mask;
  logic [PA_W-1:0]   leaf_phys;
  logic              upd_en;
  logic [WORD_W-1:0] upd_value;
  logic              wr_in_range;

  always_comb begin
    is_high    = cur_va[ptw_pkg::BIT_HIGH];
    next_table = (level != 2'd3) && rd_data[ptw_pkg::BIT_TABLE];
    leaf_write = !rd_data[ptw_pkg::BIT_RO];
    leaf_exec  = is_high ? !rd_data[ptw_pkg::BIT_PXN] : !rd_data[ptw_pkg::BIT_UXN];
    // A shift of 48 or more clears the one, so the mask becomes all ones.
    low_mask   = (PA_W'(1) << s_cur) - PA_W'(1);
    leaf_phys  = (rd_data[PA_W-1:0] & addr_mask) | (cur_va[PA_W-1:0] & low_mask);

    upd_en    = 1'b0;
    upd_value = rd_data;
    priority case (cur_type)
      ptw_pkg::REQ_MAKE_RW: begin
        upd_en                     = !leaf_write;
        upd_value[ptw_pkg::BIT_RO] = 1'b0;
      end
      ptw_pkg::REQ_MAKE_RO: begin
        upd_en                     = leaf_write;
        upd_value[ptw_pkg::BIT_RO] = 1'b1;
      end
      ptw_pkg::REQ_MAKE_EXEC: begin
        upd_en = 1'b1;
        if (is_high) begin
          upd_value[ptw_pkg::BIT_PXN] = 1'b0;
        end else begin
          upd_value[ptw_pkg::BIT_UXN] = 1'b0;
        end
      end
      default: begin
        upd_en = 1'b0;
      end
    endcase

    wr_in_range = {20'd0, req.word_index} < 32'(STORE_WORDS);

    // The store is written either by a table word write as it is accepted, or
    // by a leaf update in the decode cycle; the two never coincide.
    if (in_fire && (req.req_type == ptw_pkg::REQ_WRITE)) begin
      mem_we    = wr_in_range;
      mem_waddr = AW'(req.word_index);
      mem_wdata = req.word_value;
    end else begin
      mem_we    = (state == S_EVAL) && rd_data[ptw_pkg::BIT_VALID] && !next_table && upd_en;
      mem_waddr = pa_r[AW+2:3];
      mem_wdata = upd_value;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer and result register.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // In the final state the result register is refilled instead when it is free.
      if (out_valid && rsp.ready && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            cur_type       <= req.req_type;
            cur_va         <= req.virt_addr;
            res_status     <= ptw_pkg::ST_OK;
            res_found      <= 1'b0;
            res_entry      <= '0;
            res_level      <= '0;
            res_phys       <= '0;
            res_entry_phys <= '0;
            res_write      <= 1'b0;
            res_exec       <= 1'b0;
            res_user       <= 1'b0;
            state          <= (req.req_type == ptw_pkg::REQ_WRITE) ? S_FINISH : S_CHECK;
          end
        end
        S_CHECK: begin
          if (!gran_ok) begin
            res_status <= ptw_pkg::ST_GRANULE;
            state      <= S_FINISH;
          end else if (!size_ok || too_deep) begin
            res_status <= ptw_pkg::ST_SIZE;
            state      <= S_FINISH;
          end else begin
            table_base  <= (cur_va[ptw_pkg::BIT_HIGH] ? high_table_base : low_table_base)
                           & addr_mask;
            level       <= 2'd3 - levels_m1;
            s_cur       <= s_start;
            first_level <= 1'b1;
            state       <= S_ADDR;
          end
        end
        S_ADDR: begin
          if (outside) begin
            res_status <= ptw_pkg::ST_OUTSIDE;
            state      <= S_FINISH;
          end else begin
            pa_r  <= pa_c;
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (!rd_data[ptw_pkg::BIT_VALID]) begin
            res_status <= ptw_pkg::ST_INVALID;
            state      <= S_FINISH;
          end else if (next_table) begin
            table_base  <= rd_data[PA_W-1:0] & addr_mask;
            level       <= level + 2'd1;
            s_cur       <= s_cur - lvl_bits;
            first_level <= 1'b0;
            state       <= S_ADDR;
          end else begin
            res_status     <= ((cur_type == ptw_pkg::REQ_MAKE_RW) ||
                               (cur_type == ptw_pkg::REQ_MAKE_RO)) && !upd_en
                              ? ptw_pkg::ST_ALREADY : ptw_pkg::ST_OK;
            res_found      <= 1'b1;
            res_entry      <= rd_data;
            res_level      <= level;
            res_phys       <= leaf_phys;
            res_entry_phys <= pa_r;
            res_write      <= leaf_write;
            res_exec       <= leaf_exec;
            res_user       <= rd_data[ptw_pkg::BIT_USER];
            state          <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            rsp.status     <= res_status;
            rsp.found      <= res_found;
            rsp.leaf_entry <= res_entry;
            rsp.leaf_level <= res_level;
            rsp.mapped_pa  <= res_phys;
            rsp.entry_phys <= res_entry_phys;
            rsp.can_write  <= res_write;
            rsp.can_exec   <= res_exec;
            rsp.user_ok    <= res_user;
            out_valid      <= 1'b1;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid = out_valid;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_FINISH)
    else $error("result word appeared without passing the finish state");

  a_store_write_state: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_IDLE || state == S_EVAL))
    else $error("store written outside word write or leaf update");

  a_eval_after_addr: assert property (@(posedge clk) disable iff (rst)
    state == S_EVAL |-> $past(state) == S_ADDR)
    else $error("entry decoded without a preceding store read");

  a_found_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && rsp.found) |->
      (rsp.status == ptw_pkg::ST_OK || rsp.status == ptw_pkg::ST_ALREADY))
    else $error("leaf reported together with an error status");

  a_level_advance: assert property (@(posedge clk) disable iff (rst)
    ($past(state) == S_EVAL && state == S_ADDR) |-> level == $past(level) + 2'd1)
    else $error("walk did not descend exactly one level");

endmodule
`default_nettype wire

[dv/tb_top.sv]
// Self-checking testbench of page_table_walker: directed table, then random table walks.
// Depends on ptw_pkg, ptw_req_if, ptw_rsp_if and page_table_walker from the source folder.
`timescale 1ns / 1ps
module tb_top;
  import ptw_pkg::*;

  localparam int          STORE_WORDS = StoreWordsDefault;
  localparam logic [63:0] PA_MASK64   = (64'd1 << PA_W) - 64'd1;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int          PHASE_WORDS = 65;

  // One request word and one result word, as the channels carry them.
  typedef struct packed {
    logic [REQ_TYPE_W-1:0] rtype;
    logic [VA_W-1:0]       va;
    logic [WIDX_W-1:0]     widx;
    logic [WORD_W-1:0]     wval;
  } walk_request_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                found;
    logic [WORD_W-1:0]   leaf_entry;
    logic [LEVEL_W-1:0]  leaf_level;
    logic [PA_W-1:0]     mapped_pa;
    logic [PA_W-1:0]     entry_phys;
    logic                can_write;
    logic                can_exec;
    logic                user_ok;
  } walk_result_t;

  // Where a walk ended: the leaf entry and where it sits in the store.
  typedef struct packed {
    logic [63:0] entry;
    logic [1:0]  level;
    logic [47:0] pa;
    logic [47:0] entry_pa;
    logic [11:0] word;
  } leaf_t;

  // A row of the directed table is either a register write or a request word.
  typedef enum bit {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t           kind;
    logic [1:0]          reg_idx;
    logic [63:0]         reg_val;
    walk_request_t       req;
    bit                  typed;
    logic [STATUS_W-1:0] exp_status;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;
  logic psel, penable, pwrite, pready;
  logic [4:0]  paddr;
  logic [63:0] pwdata, prdata;

  ptw_req_if req_ch();
  ptw_rsp_if rsp_ch();

  page_table_walker uut (
    .clk    (clk),
    .rst    (rst),
    .req    (req_ch),
    .rsp    (rsp_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // The testbench's own copy of the table store and of the four registers.
  // A word that was never written is tracked so that no walk ever reads one.
  logic [63:0] tbl_words   [STORE_WORDS];
  bit          tbl_written [STORE_WORDS];
  logic [1:0]  cur_granule;
  logic [5:0]  cur_va_off;
  logic [47:0] cur_low_base;
  logic [47:0] cur_high_base;

  walk_result_t pending_results[$];
  int           mismatches = 0;

  // Handshake with the result side: a nonzero value asks it to hold off, counting that value down.
  int unsigned rsp_hold_req = 0;
  // Words sent back to back with no gap, used while the result side holds off.
  int unsigned burst_left = 0;
  bit          send_calm = 0;

  // Follows the tables for va under the current registers. When the walk would read
  // a word that was never written, miss_word names it (else -1) and miss_lvl its level.
  function automatic logic [STATUS_W-1:0] walk_tables(input logic [63:0] va,
                                                       output leaf_t lf,
                                                       output int miss_word,
                                                       output int miss_lvl);
    int unsigned shift, lvl_bits, vbits, levels, s, width, start;
    logic [63:0] off_mask, addr_mask, tbl, idx, pa, e;
    lf = '0;
    miss_word = -1;
    miss_lvl = 0;
    case (cur_granule)
      GRAN_16K: shift = 14;
      GRAN_4K:  shift = 12;
      GRAN_64K: shift = 16;
      default:  return ST_GRANULE;
    endcase
    vbits = 64 - int'(cur_va_off);
    if (vbits < 36 || vbits > 52) return ST_SIZE;
    lvl_bits = shift - 3;
    levels = (vbits - shift + lvl_bits - 1) / lvl_bits;
    if (levels < 1 || levels > 4) return ST_SIZE;
    off_mask = (64'd1 << shift) - 64'd1;
    addr_mask = PA_MASK64 & ~off_mask;
    tbl = (va[BIT_HIGH] ? {16'd0, cur_high_base} : {16'd0, cur_low_base}) & addr_mask;
    start = 4 - levels;
    for (int unsigned lvl = start; lvl < 4; lvl++) begin
      s = shift + lvl_bits * (3 - lvl);
      width = lvl_bits;
      // The top level only indexes with the address bits below the virtual size.
      if (lvl == start && vbits - s < width) width = vbits - s;
      idx = (va >> s) & ((64'd1 << width) - 64'd1);
      pa = (tbl + idx * 64'd8) & PA_MASK64;
      if (pa[47:3] >= STORE_WORDS) return ST_OUTSIDE;
      if (!tbl_written[pa[14:3]]) begin
        miss_word = int'(pa[14:3]);
        miss_lvl = int'(lvl);
        return ST_OK;
      end
      e = tbl_words[pa[14:3]];
      if (!e[BIT_VALID]) return ST_INVALID;
      // A level 3 entry is a leaf whatever its table bit says.
      if (lvl < 3 && e[BIT_TABLE]) begin
        tbl = e & addr_mask;
        continue;
      end
      lf.entry = e;
      lf.level = lvl[1:0];
      lf.entry_pa = pa[47:0];
      lf.word = pa[14:3];
      lf.pa = (((e & addr_mask) | (va & ((64'd1 << s) - 64'd1))) & PA_MASK64);
      return ST_OK;
    end
    return ST_NO_LEAF;
  endfunction

  // Expected result word of one accepted request; applies its store update.
  function automatic walk_result_t predict_walk_result(walk_request_t r);
    walk_result_t res;
    leaf_t lf;
    logic [STATUS_W-1:0] st;
    logic [63:0] e;
    int mw, ml;
    logic wr, ex;
    res = '0;
    if (r.rtype == REQ_WRITE) begin
      tbl_words[r.widx] = r.wval;
      tbl_written[r.widx] = 1'b1;
      return res;
    end
    st = walk_tables(r.va, lf, mw, ml);
    if (st != ST_OK) begin
      res.status = st;
      return res;
    end
    wr = !lf.entry[BIT_RO];
    ex = r.va[BIT_HIGH] ? !lf.entry[BIT_PXN] : !lf.entry[BIT_UXN];
    e = lf.entry;
    case (r.rtype)
      REQ_MAKE_RW: begin
        if (wr) st = ST_ALREADY;
        else begin
          e[BIT_RO] = 1'b0;
          tbl_words[lf.word] = e;
        end
      end
      REQ_MAKE_RO: begin
        if (!wr) st = ST_ALREADY;
        else begin
          e[BIT_RO] = 1'b1;
          tbl_words[lf.word] = e;
        end
      end
      REQ_MAKE_EXEC: begin
        if (r.va[BIT_HIGH]) e[BIT_PXN] = 1'b0;
        else e[BIT_UXN] = 1'b0;
        tbl_words[lf.word] = e;
      end
      default: ;
    endcase
    res.status = st;
    res.found = 1'b1;
    res.leaf_entry = lf.entry;
    res.leaf_level = lf.level;
    res.mapped_pa = lf.pa;
    res.entry_phys = lf.entry_pa;
    res.can_write = wr;
    res.can_exec = ex;
    res.user_ok = lf.entry[BIT_USER];
    return res;
  endfunction

  // A random table word to fill a hole at the given level: below level 3 mostly table
  // pointers into the store, otherwise leaves with random attributes; a few invalid entries.
  function automatic logic [63:0] table_word(int lvl);
    logic [63:0] v;
    int unsigned r;
    v = {$urandom, $urandom};
    r = $urandom_range(0, 99);
    if (r < 8) v[BIT_VALID] = 1'b0;
    else if (lvl < 3 && r < 70) begin
      if (r < 66) v[47:0] = 48'($urandom_range(0, 8 * STORE_WORDS - 1));
      v[BIT_VALID] = 1'b1;
      v[BIT_TABLE] = 1'b1;
    end else begin
      v[BIT_VALID] = 1'b1;
      if (lvl < 3) v[BIT_TABLE] = 1'b0;
    end
    return v;
  endfunction

  function automatic logic [47:0] pick_base();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 7) return 48'($urandom_range(0, 8 * STORE_WORDS - 1));
    if (r == 7) return 48'd0;
    if (r == 8) return 48'hFFFF_FFFF_FFFF;
    return 48'({$urandom, $urandom});
  endfunction

  function automatic stim_row_t req_row(logic [2:0] t, logic [63:0] va, logic [11:0] wi,
                                        logic [63:0] wv, bit typed = 0,
                                        logic [2:0] st = ST_OK);
    stim_row_t row;
    row = '0;
    row.kind = ROW_REQ;
    row.req = '{rtype: t, va: va, widx: wi, wval: wv};
    row.typed = typed;
    row.exp_status = st;
    return row;
  endfunction

  function automatic stim_row_t cfg_row(logic [1:0] idx, logic [63:0] val);
    stim_row_t row;
    row = '0;
    row.kind = ROW_CFG;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 'h%0h, actual 'h%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Waits until every expected result word has come back; the block is idle then.
  task automatic wait_results_drained();
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Register write over APB: setup phase, access phase, then an idle phase with psel low so that a
  // following write does not lower and raise psel in the same step.
  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    wait_results_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    case (idx)
      REG_GRANULE:   cur_granule   = val[1:0];
      REG_VA_SIZE:   cur_va_off    = val[5:0];
      REG_LOW_BASE:  cur_low_base  = val[47:0];
      REG_HIGH_BASE: cur_high_base = val[47:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Offers one request word after a random gap and records its expected result once
  // the word is accepted. Returns at the accepting edge with valid still high, so a
  // back-to-back word keeps valid up without a drop.
  task automatic issue(walk_request_t r, bit typed, logic [STATUS_W-1:0] typed_st);
    int unsigned gap;
    walk_result_t res;
    if (burst_left != 0) begin
      burst_left--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
      gap = send_calm ? 0 : $urandom_range(0, 14);
    end
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= r.rtype;
    req_ch.virt_addr  <= r.va;
    req_ch.word_index <= r.widx;
    req_ch.word_value <= r.wval;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    res = predict_walk_result(r);
    // Rows whose outcome is plain (writes, error statuses) carry it typed in the table.
    if (typed) begin
      res = '0;
      res.status = typed_st;
    end
    pending_results.push_back(res);
  endtask

  // Result side: random stalls per word, calm stretches, and a long hold-off on request.
  initial begin : result_sink
    int unsigned stall_left, hold_left;
    bit calm;
    walk_result_t want, got;
    stall_left = 0;
    hold_left = 0;
    calm = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst !== 1'b1) begin
        if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
          got.status     = rsp_ch.status;
          got.found      = rsp_ch.found;
          got.leaf_entry = rsp_ch.leaf_entry;
          got.leaf_level = rsp_ch.leaf_level;
          got.mapped_pa  = rsp_ch.mapped_pa;
          got.entry_phys = rsp_ch.entry_phys;
          got.can_write  = rsp_ch.can_write;
          got.can_exec   = rsp_ch.can_exec;
          got.user_ok    = rsp_ch.user_ok;
          if (pending_results.size() == 0) begin
            $error("result word arrived with no expectation pending");
            mismatches++;
          end else begin
            want = pending_results.pop_front();
            check_field("status", 64'(want.status), 64'(got.status));
            check_field("found", 64'(want.found), 64'(got.found));
            check_field("leaf_entry", want.leaf_entry, got.leaf_entry);
            check_field("leaf_level", 64'(want.leaf_level), 64'(got.leaf_level));
            check_field("mapped_pa", 64'(want.mapped_pa), 64'(got.mapped_pa));
            check_field("entry_phys", 64'(want.entry_phys), 64'(got.entry_phys));
            check_field("can_write", 64'(want.can_write), 64'(got.can_write));
            check_field("can_exec", 64'(want.can_exec), 64'(got.can_exec));
            check_field("user_ok", 64'(want.user_ok), 64'(got.user_ok));
          end
          if ($urandom_range(0, 39) == 0) calm = !calm;
          stall_left = calm ? 0 : $urandom_range(0, 14);
        end
        if (rsp_hold_req != 0) begin
          hold_left = rsp_hold_req;
          rsp_hold_req = 0;
        end
        if (hold_left != 0) begin
          hold_left--;
          rsp_ch.ready <= 1'b0;
        end else if (stall_left != 0) begin
          stall_left--;
          rsp_ch.ready <= 1'b0;
        end else begin
          rsp_ch.ready <= 1'b1;
        end
      end
    end
  end

  // Watchdog over the whole run.
  int unsigned cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin : stimulus
    stim_row_t     dir_table[$];
    walk_request_t rq, fill;
    logic [63:0]   va_pool[$];
    leaf_t         scratch;
    logic [1:0]    g;
    logic [5:0]    o;
    int            miss_w, miss_l;
    int unsigned   r, sent;

    req_ch.valid      <= 1'b0;
    req_ch.req_type   <= REQ_WALK;
    req_ch.virt_addr  <= '0;
    req_ch.word_index <= '0;
    req_ch.word_value <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    rst     <= 1'b1;
    cur_granule   = GRAN_4K;
    cur_va_off    = 6'd16;
    cur_low_base  = '0;
    cur_high_base = '0;
    foreach (tbl_written[i]) tbl_written[i] = 1'b0;

    // Directed part. With the reset settings (4K granule, 48-bit addresses, both bases
    // zero) the walk takes four levels; the rows below build one chain of tables
    // 0 -> 0x1000 -> 0x2000 -> 0x3000 and hang a page, a level 2 block and a level 0
    // block off it. Every walk reads only words written before it.
    dir_table.push_back(req_row(REQ_WRITE, 64'd0, 12'd0, 64'd0, 1, ST_OK));
    dir_table.push_back(req_row(REQ_WALK, 64'd0, 12'hFFF, '1, 1, ST_INVALID));
    dir_table.push_back(req_row(REQ_WRITE, '1, 12'hFFF, '1, 1, ST_OK));
    dir_table.push_back(req_row(REQ_WRITE, 64'd0, 12'h000, 64'h1003, 1, ST_OK));
    dir_table.push_back(req_row(REQ_WRITE, 64'd0, 12'h200, 64'h2003, 1, ST_OK));
    dir_table.push_back(req_row(REQ_WRITE, 64'd0, 12'h400, 64'h3003, 1, ST_OK));
    // Level 3 page with its table bit clear, user access on, UXN set.
    dir_table.push_back(req_row(REQ_WRITE, 64'd0, 12'h600, 64'h0040_0000_0000_7041, 1, ST_OK));
    dir_table.push_back(req_row(REQ_WALK, 64'hABC, 12'd0, 64'd0));
    // Permission edits: already writable, then read-only twice, back, then executable.
    dir_table.push_back(req_row(REQ_MAKE_RW, 64'hABC, 12'd0, 64'd0));
    dir_table.push_back(req_row(REQ_MAKE_RO, 64'hABC, 12'd0, 64'd0));
    dir_table.push_back(req_row(REQ_MAKE_RO, 64'hABC, 12'd0, 64'd0));
    dir_table.push_back(req_row(REQ_MAKE_RW, 64'hABC, 12'd0, 64'd0));
    dir_table.push_back(req_row(REQ_MAKE_EXEC, 64'hABC, 12'd0, 64'd0));
    // Level 2 block with attribute bits above the address field.
    dir_table.push_back(req_row(REQ_WRITE, 64'd0, 12'h401, 64'hFFFF_0000_0020_0001, 1, ST_OK));
    dir_table.push_back(req_row(REQ_WALK, 64'h0020_0567, 12'd0, 64'd0));
    // High half address: same tables through the high base, PXN is the exec bit.
    dir_table.push_back(req_row(REQ_MAKE_EXEC, 64'hFFFF_0000_0000_0123, 12'd0, 64'd0));
    // Level 0 block, walked through an unknown request code.
    dir_table.push_back(req_row(REQ_WRITE, 64'd0, 12'h001, 64'h0020_0080_0000_0001, 1, ST_OK));
    dir_table.push_back(req_row(3'(7), 64'h0000_0080_1234_5678, 12'd0, 64'd0));
    // Unsupported granule, then address sizes out of range.
    dir_table.push_back(cfg_row(REG_GRANULE, 64'(GRAN_NONE)));
    dir_table.push_back(req_row(REQ_WALK, '1, 12'd0, 64'd0, 1, ST_GRANULE));
    dir_table.push_back(cfg_row(REG_GRANULE, 64'(GRAN_4K)));
    dir_table.push_back(cfg_row(REG_VA_SIZE, 64'd15));
    dir_table.push_back(req_row(REQ_MAKE_RO, 64'd0, 12'd0, 64'd0, 1, ST_SIZE));
    dir_table.push_back(cfg_row(REG_VA_SIZE, 64'd63));
    dir_table.push_back(req_row(REQ_WALK, 64'd0, 12'd0, 64'd0, 1, ST_SIZE));
    dir_table.push_back(cfg_row(REG_VA_SIZE, 64'd0));
    dir_table.push_back(req_row(REQ_WALK, 64'd0, 12'd0, 64'd0, 1, ST_SIZE));
    // Top table beyond the store.
    dir_table.push_back(cfg_row(REG_VA_SIZE, 64'd16));
    dir_table.push_back(cfg_row(REG_LOW_BASE, 64'hFFFF_FFFF_FFFF));
    dir_table.push_back(req_row(REQ_MAKE_EXEC, 64'd0, 12'd0, 64'd0, 1, ST_OUTSIDE));
    dir_table.push_back(cfg_row(REG_HIGH_BASE, 64'hFFFF_FFFF_FFFF));
    dir_table.push_back(req_row(REQ_WALK, 64'h8000_0000_0000_0000, 12'd0, 64'd0, 1, ST_OUTSIDE));

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_table[i]) begin
      if (dir_table[i].kind == ROW_CFG) write_reg(dir_table[i].reg_idx, dir_table[i].reg_val);
      else issue(dir_table[i].req, dir_table[i].typed, dir_table[i].exp_status);
    end

    // Random part, in phases of register settings. Each phase starts idle, writes all
    // four registers, then mostly walks and edits addresses whose path gets filled in
    // on demand, with some reuse of recent addresses so that edits hit the same leaves.
    for (int p = 0; p < 7; p++) begin
      case (p)
        0: begin g = GRAN_4K;  o = 6'd16; end
        1: begin g = GRAN_16K; o = 6'($urandom_range(12, 28)); end
        2: begin g = GRAN_64K; o = 6'd12; end
        3: begin g = GRAN_4K;  o = 6'd28; end
        4: begin g = GRAN_16K; o = 6'd12; end
        5: begin g = GRAN_64K; o = 6'd28; end
        default: begin g = 2'($urandom_range(0, 3)); o = 6'($urandom_range(0, 63)); end
      endcase
      write_reg(REG_GRANULE, 64'(g));
      write_reg(REG_VA_SIZE, 64'(o));
      write_reg(REG_LOW_BASE, 64'(pick_base()));
      write_reg(REG_HIGH_BASE, 64'(pick_base()));
      va_pool.delete();
      // In one phase the result side stops for a long stretch while words keep coming,
      // so the walker fills up and pushes back on its input.
      if (p == 1) begin
        rsp_hold_req = 400;
        burst_left = 60;
      end
      sent = 0;
      while (sent < PHASE_WORDS) begin
        rq.va   = {$urandom, $urandom};
        rq.widx = 12'($urandom);
        rq.wval = {$urandom, $urandom};
        r = $urandom_range(0, 99);
        if (r < 10) begin
          rq.rtype = REQ_WRITE;
        end else begin
          if (r < 40) rq.rtype = REQ_WALK;
          else if (r < 55) rq.rtype = REQ_MAKE_RW;
          else if (r < 70) rq.rtype = REQ_MAKE_RO;
          else if (r < 85) rq.rtype = REQ_MAKE_EXEC;
          else rq.rtype = 3'($urandom_range(int'(REQ_MAKE_EXEC) + 1, 7));
          if (va_pool.size() != 0 && $urandom_range(0, 1) == 1)
            rq.va = va_pool[$urandom_range(0, va_pool.size() - 1)] ^
                    64'($urandom_range(0, 4095));
          // Fill in every store word the walk would read before it was ever written.
          do begin
            void'(walk_tables(rq.va, scratch, miss_w, miss_l));
            if (miss_w >= 0) begin
              fill.rtype = REQ_WRITE;
              fill.va    = {$urandom, $urandom};
              fill.widx  = 12'(miss_w);
              fill.wval  = table_word(miss_l);
              issue(fill, 0, ST_OK);
              sent++;
            end
          end while (miss_w >= 0);
          va_pool.push_back(rq.va);
          if (va_pool.size() > 32) void'(va_pool.pop_front());
        end
        issue(rq, 0, ST_OK);
        sent++;
      end
    end

    // Drain, then keep the clock running so that any stray result word would still show.
    wait_results_drained();
    repeat (24) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
